// ===== rtl/mpct_pkg.sv =====
`default_nettype none

package mpct_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CoordW = 10;
  localparam int unsigned DxW    = 9;
  localparam int unsigned DyW    = 10;
  localparam int unsigned BtnW   = 3;
  localparam int unsigned QuotW  = 8;   // signed delta / 3, |q| <= 85
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] ACK_BYTE     = 8'hFA;
  localparam logic [ByteW-1:0] SYNC_OR_MASK = 8'h37;
  localparam logic [ByteW-1:0] SYNC_MATCH   = 8'h3F;

  localparam int unsigned XSignBit = 4;
  localparam int unsigned YSignBit = 5;

  localparam int unsigned XMargin = 9;
  localparam int unsigned YMargin = 1;

  localparam logic [CoordW-1:0] WIDTH_RST  = 10'd320;
  localparam logic [CoordW-1:0] HEIGHT_RST = 10'd200;
  localparam logic [CoordW-1:0] POS_X_RST  = 10'd152;
  localparam logic [CoordW-1:0] POS_Y_RST  = 10'd92;

  localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 2'd1;

  // 1/3 ~= 171/512, exact for magnitudes below 512
  localparam logic [7:0] RECIP3 = 8'd171;

  // signed divide by 3, truncated toward zero
  function automatic logic signed [QuotW-1:0] div3(input logic signed [9:0] d);
    logic [9:0]  mag;
    logic [17:0] prod;
    logic [QuotW-1:0] q;
    mag  = d[9] ? 10'(-d) : 10'(d);
    prod = 18'(mag) * 18'(RECIP3);
    q    = QuotW'(prod[17:9]);
    div3 = d[9] ? $signed(QuotW'(-q)) : $signed(q);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mpct_cursor_update.sv =====
`default_nettype none

module mpct_cursor_update import mpct_pkg::*; #(
  parameter int unsigned Margin = XMargin
) (
  input  wire logic [CoordW-1:0]        pos,
  input  wire logic signed [9:0]        delta,
  input  wire logic [CoordW-1:0]        screen_size,
  output logic      [CoordW-1:0]        pos_next
);

  logic signed [CoordW:0]   lim_raw;
  logic        [CoordW-1:0] lim;
  logic signed [QuotW-1:0]  step;
  logic signed [CoordW+1:0] sum;

  always_comb begin
    lim_raw = $signed({1'b0, screen_size}) - $signed((CoordW + 1)'(Margin));
    // limit saturates at zero on tiny screens
    lim  = lim_raw[CoordW] ? '0 : lim_raw[CoordW-1:0];
    step = div3(delta);
    sum  = $signed({2'b00, pos}) + $signed({{(CoordW + 2 - QuotW){step[QuotW-1]}}, step});
    if (sum[CoordW+1]) begin
      pos_next = '0;
    end else if (sum[CoordW:0] > {1'b0, lim}) begin
      pos_next = lim;
    end else begin
      pos_next = sum[CoordW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mouse_packet_cursor_tracker.sv =====
// PS/2 mouse packet decoder with cursor tracking.
// Input channel (in_valid / in_stall / mouse_byte): one raw mouse byte per
// request. After reset the block drops bytes until the 0xFA acknowledge, then
// syncs on a header byte (bits 7:6 clear, bit 3 set) and collects X and Y.
// Output channel (out_valid / out_stall): one request per complete packet with
// buttons, sign-extended deltas (Y negated, screen-down positive) and the
// cursor after moving by delta/3 and clamping to the screen.
// Configuration: cfg_we writes cfg_data into screen width (index 0) or screen
// height (index 1); other indexes are dropped. Write only while idle.
// Timing: one byte per cycle sustained unless out_stall holds a result. A
// byte passes through the input register, is decoded and the cursor
// updated in one pass, and the result is registered in the output register.
// Reset: width 320, height 200, cursor (152, 92), waiting for acknowledge.
// When out_stall holds a pending result, the input register fills and then
// in_stall rises; nothing is dropped.

`default_nettype none

module mouse_packet_cursor_tracker import mpct_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [ByteW-1:0]           mouse_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [BtnW-1:0]                 buttons,
  output logic signed [DxW-1:0]           delta_x,
  output logic signed [DyW-1:0]           delta_y,
  output logic [CoordW-1:0]               cursor_x,
  output logic [CoordW-1:0]               cursor_y,
  input  wire logic                       cfg_we,
  input  wire logic [CfgIdxW-1:0]         cfg_index,
  input  wire logic [CoordW-1:0]          cfg_data
);

  typedef enum logic [3:0] {
    PH_ACK = 4'b0001,
    PH_HDR = 4'b0010,
    PH_X   = 4'b0100,
    PH_Y   = 4'b1000
  } phase_t;

  phase_t             phase, phase_next;
  logic [ByteW-1:0]   header_byte, x_byte;
  logic [CoordW-1:0]  pos_x, pos_y;
  logic [CoordW-1:0]  screen_width, screen_height;

  logic               in_full;
  logic [ByteW-1:0]   in_byte;

  logic               advance, fire, emit, hdr_ok;
  logic signed [DxW-1:0] dx;
  logic signed [DxW-1:0] dy_raw;
  logic signed [DyW-1:0] dy;
  logic [CoordW-1:0]  new_x, new_y;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;
  assign fire     = in_full && advance;
  assign hdr_ok   = (in_byte | SYNC_OR_MASK) == SYNC_MATCH;
  assign emit     = fire && (phase == PH_Y);

  assign dx     = $signed({header_byte[XSignBit], x_byte});
  assign dy_raw = $signed({header_byte[YSignBit], in_byte});
  assign dy     = -$signed({dy_raw[DxW-1], dy_raw});

  always_comb begin
    phase_next = phase;
    if (fire) begin
      case (phase)
        PH_ACK:  if (in_byte == ACK_BYTE) phase_next = PH_HDR;
        PH_HDR:  if (hdr_ok) phase_next = PH_X;
        PH_X:    phase_next = PH_Y;
        PH_Y:    phase_next = PH_HDR;
        default: phase_next = PH_ACK;
      endcase
    end
  end

  mpct_cursor_update #(.Margin(XMargin)) u_upd_x (
    .pos         (pos_x),
    .delta       ($signed({dx[DxW-1], dx})),
    .screen_size (screen_width),
    .pos_next    (new_x)
  );

  mpct_cursor_update #(.Margin(YMargin)) u_upd_y (
    .pos         (pos_y),
    .delta       (dy),
    .screen_size (screen_height),
    .pos_next    (new_y)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_byte <= mouse_byte;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // packet state and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_ACK;
      header_byte <= '0;
      x_byte      <= '0;
      pos_x       <= POS_X_RST;
      pos_y       <= POS_Y_RST;
    end else begin
      phase <= phase_next;
      if (fire && phase == PH_HDR && hdr_ok) begin
        header_byte <= in_byte;
      end
      if (fire && phase == PH_X) begin
        x_byte <= in_byte;
      end
      if (emit) begin
        pos_x <= new_x;
        pos_y <= new_y;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end
    if (emit) begin
      buttons  <= header_byte[BtnW-1:0];
      delta_x  <= dx;
      delta_y  <= dy;
      cursor_x <= new_x;
      cursor_y <= new_y;
    end
  end

  a_y_byte_emits: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_Y |=> out_valid && phase == PH_HDR)
    else $error("Y byte did not produce a result");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_byte))
    else $error("input register lost a blocked byte");

  a_ack_once: assert property (@(posedge clk) disable iff (rst)
    phase != PH_ACK |=> phase != PH_ACK)
    else $error("returned to acknowledge wait without reset");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  import mpct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;
  localparam int SpeedDiv     = 3;
  localparam int NumPhases    = 8;
  localparam int PhaseItems   = 100;
  localparam int SettleCycles = 6;
  localparam int QuietLimit   = 2000;
  localparam int IdlePct      = 24;

  typedef enum logic [1:0] {WAIT_ACK, WAIT_HEADER, WAIT_X, WAIT_Y} pkt_phase_t;

  typedef struct packed {
    logic [BtnW-1:0]   buttons;
    logic [DxW-1:0]    dx;
    logic [DyW-1:0]    dy;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
  } motion_report_t;

  class cursor_scoreboard;
    pkt_phase_t       phase;
    logic [ByteW-1:0] header;
    logic [ByteW-1:0] x_raw;
    int               pos_x, pos_y, width, height;
    int               failures;
    motion_report_t   pending_reports[$];

    function new();
      phase    = WAIT_ACK;
      header   = '0;
      x_raw    = '0;
      pos_x    = int'(POS_X_RST);
      pos_y    = int'(POS_Y_RST);
      width    = int'(WIDTH_RST);
      height   = int'(HEIGHT_RST);
      failures = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] val);
      if (idx == REG_SCREEN_WIDTH) width = int'(val);
      else if (idx == REG_SCREEN_HEIGHT) height = int'(val);
    endfunction

    // limit saturates at zero; negative goes to 0 before the upper clamp
    static function int clamp(int p, int lim);
      if (lim < 0) lim = 0;
      if (p < 0) p = 0;
      if (p > lim) p = lim;
      return p;
    endfunction

    function void take_byte(logic [ByteW-1:0] b);
      int dx, dy;
      motion_report_t m;
      case (phase)
        WAIT_ACK: begin
          if (b == ACK_BYTE) phase = WAIT_HEADER;
        end
        WAIT_HEADER: begin
          if ((b | SYNC_OR_MASK) == SYNC_MATCH) begin
            header = b;
            phase  = WAIT_X;
          end
        end
        WAIT_X: begin
          x_raw = b;
          phase = WAIT_Y;
        end
        default: begin
          phase = WAIT_HEADER;
          dx = int'(x_raw) - (header[XSignBit] ? 256 : 0);
          dy = -(int'(b) - (header[YSignBit] ? 256 : 0));
          pos_x = clamp(pos_x + dx / SpeedDiv, width - int'(XMargin));
          pos_y = clamp(pos_y + dy / SpeedDiv, height - int'(YMargin));
          m.buttons = header[BtnW-1:0];
          m.dx      = DxW'(dx);
          m.dy      = DyW'(dy);
          m.cx      = CoordW'(pos_x);
          m.cy      = CoordW'(pos_y);
          pending_reports.push_back(m);
        end
      endcase
    endfunction

    function void match_report(motion_report_t got);
      motion_report_t want;
      if (pending_reports.size() == 0) begin
        $error("unexpected report: buttons %0d dx %0d dy %0d x %0d y %0d", got.buttons,
               $signed(got.dx), $signed(got.dy), got.cx, got.cy);
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.buttons !== want.buttons) begin
        $error("buttons: expected %0d, got %0d", want.buttons, got.buttons);
        failures++;
      end
      if (got.dx !== want.dx) begin
        $error("delta_x: expected %0d, got %0d", $signed(want.dx), $signed(got.dx));
        failures++;
      end
      if (got.dy !== want.dy) begin
        $error("delta_y: expected %0d, got %0d", $signed(want.dy), $signed(got.dy));
        failures++;
      end
      if (got.cx !== want.cx) begin
        $error("cursor_x: expected %0d, got %0d", want.cx, got.cx);
        failures++;
      end
      if (got.cy !== want.cy) begin
        $error("cursor_y: expected %0d, got %0d", want.cy, got.cy);
        failures++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ByteW-1:0]    mouse_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BtnW-1:0]     buttons;
  logic signed [DxW-1:0] delta_x;
  logic signed [DyW-1:0] delta_y;
  logic [CoordW-1:0]   cursor_x;
  logic [CoordW-1:0]   cursor_y;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CoordW-1:0]   cfg_data = '0;

  cursor_scoreboard cursor_track = new();
  logic             calm = 1'b0;
  logic             drift_x = 1'b0;
  logic             drift_y = 1'b0;
  int               quiet_cycles = 0;
  logic [ByteW-1:0] opening_bytes [0:24];

  mouse_packet_cursor_tracker dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mouse_byte (mouse_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .buttons    (buttons),
    .delta_x    (delta_x),
    .delta_y    (delta_y),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // report side: random backpressure, check on every accepted request
  always @(posedge clk) begin
    motion_report_t got;
    if (!rst && out_valid && !out_stall) begin
      got.buttons = buttons;
      got.dx      = delta_x;
      got.dy      = delta_y;
      got.cx      = cursor_x;
      got.cy      = cursor_y;
      cursor_track.match_report(got);
    end
    out_stall <= !calm && ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    if (!calm) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    mouse_byte <= b;
    do @(posedge clk); while (in_stall);
    cursor_track.take_byte(b);
  endtask

  // drop valid, wait for every outstanding report, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (cursor_track.pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cursor_track.set_register(idx, val);
  endtask

  task automatic program_screen(input logic [CoordW-1:0] w, input logic [CoordW-1:0] h);
    write_reg(REG_SPARE_A, CoordW'($urandom));
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SPARE_B, CoordW'($urandom));
    write_reg(REG_SCREEN_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // well-formed packet; sign bits follow a slowly flipping drift so the
  // cursor gets pushed into both edges
  task automatic send_packet();
    logic [ByteW-1:0] hdr;
    logic             sx, sy;
    if ($urandom_range(99) < 5) drift_x = ~drift_x;
    if ($urandom_range(99) < 5) drift_y = ~drift_y;
    sx  = ($urandom_range(1) == 0) ? drift_x : 1'($urandom);
    sy  = ($urandom_range(1) == 0) ? drift_y : 1'($urandom);
    hdr = {2'b00, sy, sx, 1'b1, 3'($urandom)};
    send_byte(hdr);
    send_byte(ByteW'($urandom));
    send_byte(ByteW'($urandom));
  endtask

  initial begin
    int sent;
    int pressure_at;
    logic [CoordW-1:0] w, h;

    opening_bytes = '{
      8'h00, 8'hFF, 8'hFB, ACK_BYTE,        // dropped until acknowledge
      ACK_BYTE, 8'hC8, 8'h37,               // headers failing sync
      8'h08, 8'h00, 8'h00,                  // zero motion
      8'h3F, 8'h00, 8'h00,                  // all buttons, most negative x, y -> +256
      8'h08, 8'hFF, 8'hFF,                  // x +255, y -> -255
      8'h0F, 8'hFF, 8'h00,
      8'h18, 8'h01, 8'h80,
      8'h09, 8'h7F, 8'h81
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1:       begin w = 10'd0;    h = 10'd0;    end
        2:       begin w = 10'd1023; h = 10'd1023; end
        3:       begin w = 10'd8;    h = 10'd1;    end
        4:       begin w = 10'd9;    h = 10'd2;    end
        5:       begin w = 10'd16;   h = 10'd16;   end
        6:       begin w = CoordW'($urandom_range(1023, 16)); h = CoordW'($urandom_range(1023, 16)); end
        default: begin w = CoordW'($urandom); h = CoordW'($urandom); end
      endcase
      if (p > 0) program_screen(w, h);
      calm = (p == 2);
      pressure_at = (p == 4) ? PhaseItems / 2 : -1;
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(99) < 10) begin
          send_byte(ByteW'($urandom));
          sent += 1;
        end else begin
          send_packet();
          sent += 3;
        end
        if (pressure_at >= 0 && sent >= pressure_at) begin
          settle();
          pressure_at = -1;
        end
      end
      settle();
    end
    calm = 1'b0;

    if (cursor_track.failures == 0 && cursor_track.pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
